// ----- design/sha1he_pkg.sv -----
// shared types, constants and helper functions of the sha-1 hash engine
`default_nettype none

package sha1he_pkg;

   // initial chaining values
   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hefcdab89;
   localparam logic [31:0] INIT_H2 = 32'h98badcfe;
   localparam logic [31:0] INIT_H3 = 32'h10325476;
   localparam logic [31:0] INIT_H4 = 32'hc3d2e1f0;

   // round constants
   localparam logic [31:0] ROUND_K0 = 32'h5a827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ed9eba1;
   localparam logic [31:0] ROUND_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] ROUND_K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [6:0] ROUND_B1   = 7'd20;
   localparam logic [6:0] ROUND_B2   = 7'd40;
   localparam logic [6:0] ROUND_B3   = 7'd60;
   localparam logic [2:0] LAST_INDEX = 3'd4;
   localparam logic [2:0] MAX_BYTES  = 3'd4;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       insert;
      logic       pad;
      logic       pad_marked;
      logic       load_vars;
      logic       round;
      logic [6:0] rnd;
      logic       add_chain;
      logic       out_shift;
      logic [2:0] out_idx;
      logic       clear_len;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic len_fits;
   } status_type;

   function automatic logic [31:0] init_value(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0:    v = INIT_H0;
         3'd1:    v = INIT_H1;
         3'd2:    v = INIT_H2;
         3'd3:    v = INIT_H3;
         default: v = INIT_H4;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rotl1(input logic [31:0] v);
      return {v[30:0], v[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] v);
      return {v[26:0], v[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] v);
      return {v[1:0], v[31:2]};
   endfunction

endpackage

`default_nettype wire

// ----- design/sha1_hash_engine_core.sv -----
// top level of the sha-1 hash engine: controller, datapath and checks
//
// sha-1 engine fed one big-endian 32-bit word at a time; byte_count gives the
// valid bytes from the top of the word (values above four act as four), and
// the word with last set closes the message, after which five digest words
// h0..h4 leave on the rsp channel. the engine handles one word at a time:
// req_stall is low only when it is idle. a full word is taken and then its
// bytes are packed into the window; every completed 64-byte block adds the
// loading of the working variables, 80 rounds at one round per cycle from the
// single round unit, the chaining add and a second packing pass for the bytes
// left over. the closing word adds a padding step and the final block, another
// block when fewer than nine bytes of the block are left, then the digest
// readout, which rsp_stall can hold. partial words are meant only for the
// closing word; a partial word elsewhere is packed at byte granularity. the
// byte length wraps modulo 2^61
`default_nettype none

module sha1_hash_engine_core import sha1he_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   cmd_type    cmd;
   status_type status;

   // sequencer: word intake, padding, round count, digest readout
   sha1he_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_word.last),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   // window, round registers, chaining words and length counter
   sha1he_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

   // a taken word always keeps the engine busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine took a word while packing the previous one");

   // no word is taken while the digest is being read out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("word taken during digest readout");

   // digest words leave in order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_word.last_word) |=>
         (rsp_valid && (rsp_word.word_index == $past(rsp_word.word_index) + 3'd1)))
      else $error("digest word index out of sequence");

   // after the fifth digest word the engine is back to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word.last_word) |=> (!rsp_valid && !req_stall))
      else $error("engine not idle after the final digest word");

endmodule

`default_nettype wire

// ----- design/sha1he_ctrl.sv -----
// sequencing state machine of the sha-1 hash engine
`default_nettype none

module sha1he_ctrl import sha1he_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall,
   output logic       rsp_valid
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_INSERT = 7'b0000010,
      ST_PAD    = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_ROUND  = 7'b0010000,
      ST_ADD    = 7'b0100000,
      ST_OUTPUT = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       last_ff, last_in;
   logic       marked_ff, marked_in;
   logic       final_ff, final_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in       = state_ff;
      last_in        = last_ff;
      marked_in      = marked_ff;
      final_in       = final_ff;
      rnd_in         = rnd_ff;
      idx_in         = idx_ff;
      cmd            = '0;
      cmd.rnd        = rnd_ff;
      cmd.out_idx    = idx_ff;
      cmd.pad_marked = marked_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               last_in       = req_last;
               state_in      = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            if (status.full) begin
               state_in = ST_LOAD;
            end else if (last_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.pad  = 1'b1;
            final_in = marked_ff | status.len_fits;
            if (!marked_ff && !status.len_fits) begin
               marked_in = 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_vars = 1'b1;
            rnd_in        = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (rnd_ff == LAST_ROUND) begin
               rnd_in   = '0;
               state_in = ST_ADD;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            if (final_ff) begin
               idx_in   = '0;
               state_in = ST_OUTPUT;
            end else if (marked_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               cmd.out_shift = 1'b1;
               if (idx_ff == LAST_INDEX) begin
                  cmd.clear_len = 1'b1;
                  last_in       = 1'b0;
                  marked_in     = 1'b0;
                  final_in      = 1'b0;
                  idx_in        = '0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUTPUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         last_ff   <= 1'b0;
         marked_ff <= 1'b0;
         final_ff  <= 1'b0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         marked_ff <= marked_in;
         final_ff  <= final_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sha1he_dpath.sv -----
// byte packing, schedule window, round logic and chaining words of the sha-1 hash engine
`default_nettype none

module sha1he_dpath import sha1he_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  cmd_type      cmd,
   output status_type   status,
   output rsp_word_type rsp_word
);

   logic [15:0][3:0][7:0] win_ff, win_in;
   logic [4:0][31:0]      var_ff, var_in;
   logic [4:0][31:0]      chain_ff, chain_in;
   logic [60:0]           len_ff, len_in;
   logic [3:0][7:0]       data_ff, data_in;
   logic [2:0]            rem_ff, rem_in;

   logic [5:0]       pos;
   logic [6:0]       sum7;
   logic [6:0]       space;
   logic [2:0]       nbytes;
   logic             full;
   logic             len_fits;
   logic             len_write;
   logic [7:0][7:0]  bit_len;
   logic [63:0][5:0] lane_off;
   logic [31:0]      sched_w;
   logic [31:0]      fval;
   logic [31:0]      kval;
   logic [31:0]      tmp;
   logic [2:0]       count_clamped;

   assign pos       = len_ff[5:0];
   assign sum7      = {1'b0, pos} + {4'b0000, rem_ff};
   assign full      = sum7[6];
   assign space     = 7'd64 - {1'b0, pos};
   assign nbytes    = full ? space[2:0] : rem_ff;
   assign len_fits  = (pos[5:3] != 3'b111);
   assign len_write = cmd.pad_marked | len_fits;
   assign bit_len   = {len_ff, 3'b000};

   assign status.full     = full;
   assign status.len_fits = len_fits;

   assign count_clamped = (req_word.byte_count > MAX_BYTES) ? MAX_BYTES : req_word.byte_count;

   always_comb begin
      for (int j = 0; j < 64; j++) begin
         lane_off[j] = 6'(j) - pos;
      end
   end

   // round function
   assign sched_w = rotl1(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0]);

   always_comb begin
      if (cmd.rnd < ROUND_B1) begin
         fval = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         kval = ROUND_K0;
      end else if (cmd.rnd < ROUND_B2) begin
         fval = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         kval = ROUND_K1;
      end else if (cmd.rnd < ROUND_B3) begin
         fval = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3]) | (var_ff[2] & var_ff[3]);
         kval = ROUND_K2;
      end else begin
         fval = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         kval = ROUND_K3;
      end
   end

   assign tmp = rotl5(var_ff[0]) + fval + var_ff[4] + win_ff[0] + kval;

   // window: byte inserts, padding, schedule shift
   always_comb begin
      win_in = win_ff;
      if (cmd.insert) begin
         for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
               if (lane_off[i*4+b] < {3'b000, nbytes}) begin
                  win_in[i][3-b] = data_ff[2'd3 - lane_off[i*4+b][1:0]];
               end
            end
         end
      end else if (cmd.pad) begin
         for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
               if (len_write && (i*4+b) >= 56) begin
                  win_in[i][3-b] = bit_len[63-(i*4+b)];
               end else if (!cmd.pad_marked && 6'(i*4+b) == pos) begin
                  win_in[i][3-b] = PAD_BYTE;
               end else if (cmd.pad_marked || 6'(i*4+b) > pos) begin
                  win_in[i][3-b] = 8'h00;
               end
            end
         end
      end else if (cmd.round) begin
         win_in[14:0] = win_ff[15:1];
         win_in[15]   = sched_w;
      end
   end

   always_comb begin
      var_in = var_ff;
      if (cmd.load_vars) begin
         var_in = chain_ff;
      end else if (cmd.round) begin
         var_in[0] = tmp;
         var_in[1] = var_ff[0];
         var_in[2] = rotl30(var_ff[1]);
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end else if (cmd.out_shift) begin
         chain_in[3:0] = chain_ff[4:1];
         chain_in[4]   = init_value(cmd.out_idx);
      end
   end

   always_comb begin
      len_in  = len_ff;
      data_in = data_ff;
      rem_in  = rem_ff;
      if (cmd.load_item) begin
         data_in = req_word.data_word;
         rem_in  = count_clamped;
      end else if (cmd.insert) begin
         len_in  = len_ff + {58'd0, nbytes};
         data_in = data_ff << {nbytes, 3'b000};
         rem_in  = rem_ff - nbytes;
      end else if (cmd.clear_len) begin
         len_in = '0;
      end
   end

   assign rsp_word.digest_word = chain_ff[0];
   assign rsp_word.word_index  = cmd.out_idx;
   assign rsp_word.last_word   = (cmd.out_idx == LAST_INDEX);

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      var_ff  <= var_in;
      data_ff <= data_in;
      rem_ff  <= rem_in;
      if (reset) begin
         chain_ff <= {INIT_H4, INIT_H3, INIT_H2, INIT_H1, INIT_H0};
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
      end
   end

endmodule

`default_nettype wire
